>>> rtl/ffba_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and field layouts of the first-fit block allocator.
package ffba_pkg;

    localparam int WORD_BYTES     = 8;
    localparam int WB_SH          = $clog2(WORD_BYTES);
    localparam int POOL_WORDS_DEF = 1024;

    // Byte offsets inside the pool, with headroom for block-end sums.
    localparam int OFF_W = 16;
    // Width of one stored block header.
    localparam int HDR_W = 14;
    localparam int CFG_W = 14;

    localparam logic [CFG_W-1:0] CFG_POOL_RESET = 14'h2000;

    localparam logic [HDR_W-1:0] FLAG_USED = HDR_W'(1);

    // Adder constants derived from the word size.
    localparam logic [OFF_W-1:0] K_WB     = OFF_W'(WORD_BYTES);
    localparam logic [OFF_W-1:0] K_RND    = OFF_W'(WORD_BYTES - 1);
    localparam logic [OFF_W-1:0] K_NWB    = OFF_W'(-WORD_BYTES);
    localparam logic [OFF_W-1:0] K_NWB_P1 = OFF_W'(1 - WORD_BYTES);
    localparam logic [OFF_W-1:0] K_N2WB   = OFF_W'(-2 * WORD_BYTES);
    localparam logic [OFF_W-1:0] K_2WB    = OFF_W'(2 * WORD_BYTES);

    localparam logic [1:0] FUNC_ALLOC = 2'd0;
    localparam logic [1:0] FUNC_FREE  = 2'd1;
    localparam logic [1:0] FUNC_QUERY = 2'd2;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_OOM  = 2'd1;
    localparam logic [1:0] ST_ZERO = 2'd2;

    typedef struct packed {
        logic [1:0]  func;
        logic [12:0] req_size;
        logic [12:0] address;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  status;
        logic [12:0] block_address;
        logic [12:0] largest_free;
    } t_out_item;

    // Operands of the shared adder: sum = a + b + k.
    typedef struct packed {
        logic [OFF_W-1:0] a;
        logic [OFF_W-1:0] b;
        logic [OFF_W-1:0] k;
    } t_alu_op;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_M_RD,
        S_M_CHK,
        S_N_RD,
        S_N_CHK,
        S_W_RD,
        S_W_CHK,
        S_A_POS,
        S_A_REM,
        S_A_HDR,
        S_F_RD,
        S_F_CHK,
        S_DONE
    } t_state;

endpackage

>>> rtl/ffba_alu.sv
`timescale 1ns / 1ps
// Shared three-operand adder used for the sequencer's offset and size sums.
module ffba_alu (
    input  ffba_pkg::t_alu_op                 i_op,
    output logic [ffba_pkg::OFF_W-1:0]        o_sum
);
    import ffba_pkg::*;

    assign o_sum = i_op.a + i_op.b + i_op.k;

endmodule

>>> rtl/ffba_ram.sv
`timescale 1ns / 1ps
// Single-port-write, registered-read memory holding the block headers.
module ffba_ram #(
    parameter int DEPTH = ffba_pkg::POOL_WORDS_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                          i_clk,
    input  logic                          i_we,
    input  logic [AW-1:0]                 i_waddr,
    input  logic [ffba_pkg::HDR_W-1:0]    i_wdata,
    input  logic                          i_re,
    input  logic [AW-1:0]                 i_raddr,
    output logic [ffba_pkg::HDR_W-1:0]    o_rdata
);
    import ffba_pkg::*;

    logic [HDR_W-1:0] r_mem [DEPTH];
    logic [HDR_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/first_fit_block_allocator.sv
`timescale 1ns / 1ps
// Top level of the first-fit block allocator: sequencer, config and result register.
// A free reads and clears its block header; a rejected or unknown request goes straight to
// the result. Allocate and query merge, then walk the chain through one header port and one
// adder, a free header also reading its neighbor during the merge. One transaction is
// worked on at a time. Reset (synchronous, active low) restores an 8192-byte pool, or the
// whole memory if smaller, and a config write the written size rounded down to a word and
// clamped to two words and the memory; the single free header is written the next cycle,
// then transactions are accepted.
module first_fit_block_allocator #(
    parameter int POOL_WORDS = ffba_pkg::POOL_WORDS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  ffba_pkg::t_in_item            i_in,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output ffba_pkg::t_out_item           o_out,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [ffba_pkg::CFG_W-1:0]    i_cfg_data
);
    import ffba_pkg::*;

    localparam int AW  = $clog2(POOL_WORDS);
    localparam int LIM = POOL_WORDS * WORD_BYTES;
    // Largest usable pool in bytes; a 14-bit config write is clamped to it.
    localparam logic [OFF_W-1:0] POOL_LIM = (LIM > 65535) ? 16'hFFF8 : OFF_W'(LIM);
    localparam logic [OFF_W-1:0] POOL_RST =
        (LIM < 32'(CFG_POOL_RESET)) ? OFF_W'(LIM) : OFF_W'(CFG_POOL_RESET);

    // Sequencer state and working registers.
    t_state           r_state, n_state;
    logic [OFF_W-1:0] r_pool,  n_pool;   // usable pool size in bytes
    logic [OFF_W-1:0] r_h,     n_h;      // offset of the current block header
    logic [OFF_W-1:0] r_n,     n_n;      // offset of the next header during a merge, or of the split header
    logic [OFF_W-1:0] r_m,     n_m;      // size of the block chosen for allocation
    logic [OFF_W-1:0] r_bs,    n_bs;     // rounded request size
    logic [HDR_W-1:0] r_best,  n_best;   // largest free payload seen by a query
    logic             r_is_query, n_is_query;
    t_out_item        r_res,   n_res;

    // Output register.
    logic             r_ovld,  n_ovld;
    t_out_item        r_out,   n_out;

    // Shared adder and header memory.
    t_alu_op          alu_op;
    logic [OFF_W-1:0] alu_sum;
    logic             ram_we, ram_re;
    logic [OFF_W-1:0] wr_off, rd_off;
    logic [HDR_W-1:0] ram_wdata, ram_rdata;
    logic [OFF_W-1:0] m_clr;

    logic             in_acc;
    logic             h_in, n_in;
    logic             hdr_used;
    logic             free_ok;
    logic             fits;
    logic [OFF_W-1:0] cfg_bytes;
    logic             split_pos_ok;

    ffba_alu u_alu (
        .i_op  (alu_op),
        .o_sum (alu_sum)
    );

    ffba_ram #(
        .DEPTH (POOL_WORDS),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (AW'(wr_off >> WB_SH)),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (AW'(rd_off >> WB_SH)),
        .o_rdata (ram_rdata)
    );

    // Configuration has priority over a transaction arriving in the same idle cycle.
    assign o_cfg_ready = (r_state == S_IDLE);
    assign o_in_ready  = (r_state == S_IDLE) && !i_cfg_valid;
    assign in_acc      = i_in_valid && o_in_ready;
    assign o_out_valid = r_ovld;
    assign o_out       = r_out;

    // Header fields as they come out of the memory.
    assign hdr_used = ram_rdata[0];
    assign m_clr    = OFF_W'(ram_rdata & ~FLAG_USED);
    assign h_in     = (r_h < r_pool);
    assign n_in     = (r_n < r_pool);
    assign fits     = !hdr_used && (OFF_W'(ram_rdata) >= r_bs);

    // A free is honored only for an aligned payload offset inside the pool.
    assign free_ok = (i_in.address != '0) && (i_in.address[WB_SH-1:0] == '0) &&
                     (OFF_W'(i_in.address) >= K_2WB) && (OFF_W'(i_in.address) < r_pool);

    // The split header must land inside the memory.
    assign split_pos_ok = (32'(r_n >> WB_SH) < POOL_WORDS);

    // Pool size register: rounded down to a word, at least two words, at most the memory.
    always_comb begin
        cfg_bytes = OFF_W'(i_cfg_data) & ~K_RND;
        if (cfg_bytes < K_2WB) begin
            cfg_bytes = K_2WB;
        end else if (cfg_bytes > POOL_LIM) begin
            cfg_bytes = POOL_LIM;
        end
    end

    // Next-state logic of the sequencer.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_INIT: n_state = S_IDLE;
            S_IDLE: begin
                if (i_cfg_valid) begin
                    n_state = S_INIT;
                end else if (i_in_valid) begin
                    unique case (i_in.func)
                        FUNC_ALLOC: n_state = (i_in.req_size == '0) ? S_DONE : S_M_RD;
                        FUNC_FREE:  n_state = free_ok ? S_F_RD : S_DONE;
                        FUNC_QUERY: n_state = S_M_RD;
                        default:    n_state = S_DONE;
                    endcase
                end
            end
            S_M_RD:  n_state = h_in ? S_M_CHK : S_W_RD;
            S_M_CHK: n_state = hdr_used ? S_M_RD : S_N_RD;
            S_N_RD:  n_state = n_in ? S_N_CHK : S_M_RD;
            S_N_CHK: n_state = hdr_used ? S_M_RD : S_N_RD;
            S_W_RD:  n_state = h_in ? S_W_CHK : S_DONE;
            S_W_CHK: n_state = (!r_is_query && fits) ? S_A_POS : S_W_RD;
            S_A_POS: n_state = S_A_REM;
            S_A_REM: n_state = S_A_HDR;
            S_A_HDR: n_state = S_DONE;
            S_F_RD:  n_state = S_F_CHK;
            S_F_CHK: n_state = S_DONE;
            S_DONE:  n_state = (!r_ovld || i_out_ready) ? S_IDLE : S_DONE;
            default: n_state = S_INIT;
        endcase
    end

    // Datapath, memory and adder control of the sequencer.
    always_comb begin
        n_pool     = r_pool;
        n_h        = r_h;
        n_n        = r_n;
        n_m        = r_m;
        n_bs       = r_bs;
        n_best     = r_best;
        n_is_query = r_is_query;
        n_res      = r_res;
        alu_op     = '0;
        ram_we     = 1'b0;
        ram_re     = 1'b0;
        wr_off     = r_h;
        rd_off     = r_h;
        ram_wdata  = '0;

        unique case (r_state)
            S_INIT: begin
                // The whole pool becomes one free block behind the reserved word.
                alu_op    = '{a: r_pool, b: '0, k: K_N2WB};
                ram_we    = 1'b1;
                wr_off    = K_WB;
                ram_wdata = alu_sum[HDR_W-1:0];
            end
            S_IDLE: begin
                if (i_cfg_valid) begin
                    n_pool = cfg_bytes;
                end else if (in_acc) begin
                    n_res      = '0;
                    n_best     = '0;
                    n_h        = K_WB;
                    n_is_query = (i_in.func == FUNC_QUERY);
                    if (i_in.func == FUNC_ALLOC) begin
                        alu_op = '{a: OFF_W'(i_in.req_size), b: '0, k: K_RND};
                        n_bs   = alu_sum & ~K_RND;
                        if (i_in.req_size == '0) begin
                            n_res.status = ST_ZERO;
                        end
                    end else if (i_in.func == FUNC_FREE) begin
                        alu_op = '{a: OFF_W'(i_in.address), b: '0, k: K_NWB};
                        n_h    = alu_sum;
                    end
                end
            end
            S_M_RD: begin
                ram_re = h_in;
                if (!h_in) begin
                    n_h = K_WB;
                end
            end
            S_M_CHK: begin
                alu_op = '{a: r_h, b: m_clr, k: K_WB};
                if (hdr_used) begin
                    n_h = alu_sum;
                end else begin
                    n_n = alu_sum;
                end
            end
            S_N_RD: begin
                if (n_in) begin
                    ram_re = 1'b1;
                    rd_off = r_n;
                end else begin
                    // Merged size is the span up to the next header minus one header.
                    alu_op    = '{a: r_n, b: ~r_h, k: K_NWB_P1};
                    ram_we    = 1'b1;
                    ram_wdata = alu_sum[HDR_W-1:0];
                    n_h       = r_n;
                end
            end
            S_N_CHK: begin
                if (hdr_used) begin
                    alu_op    = '{a: r_n, b: ~r_h, k: K_NWB_P1};
                    ram_we    = 1'b1;
                    ram_wdata = alu_sum[HDR_W-1:0];
                    n_h       = r_n;
                end else begin
                    alu_op = '{a: r_n, b: m_clr, k: K_WB};
                    n_n    = alu_sum;
                end
            end
            S_W_RD: begin
                ram_re = h_in;
                if (!h_in) begin
                    if (r_is_query) begin
                        n_res.largest_free = (OFF_W'(r_best) < K_WB) ? '0 : r_best[12:0];
                    end else begin
                        n_res.status = ST_OOM;
                    end
                end
            end
            S_W_CHK: begin
                alu_op = '{a: r_h, b: m_clr, k: K_WB};
                if (r_is_query) begin
                    if (!hdr_used && (ram_rdata > r_best)) begin
                        n_best = ram_rdata;
                    end
                    n_h = alu_sum;
                end else if (fits) begin
                    n_m = OFF_W'(ram_rdata);
                end else begin
                    n_h = alu_sum;
                end
            end
            S_A_POS: begin
                alu_op = '{a: r_h, b: r_bs, k: K_WB};
                n_n    = alu_sum;
            end
            S_A_REM: begin
                // Remainder m - bs - WORD_BYTES; a negative sign means no room to split.
                alu_op    = '{a: r_m, b: ~r_bs, k: K_NWB_P1};
                ram_we    = !alu_sum[OFF_W-1] && split_pos_ok;
                wr_off    = r_n;
                ram_wdata = alu_sum[HDR_W-1:0];
            end
            S_A_HDR: begin
                alu_op              = '{a: r_h, b: '0, k: K_WB};
                ram_we              = 1'b1;
                ram_wdata           = r_bs[HDR_W-1:0] | FLAG_USED;
                n_res.block_address = alu_sum[12:0];
            end
            S_F_RD: begin
                ram_re = 1'b1;
            end
            S_F_CHK: begin
                ram_we    = 1'b1;
                ram_wdata = ram_rdata & ~FLAG_USED;
            end
            S_DONE: begin
            end
            default: begin
            end
        endcase
    end

    // Result register: loaded when the sequencer finishes and the slot is empty or being read.
    always_comb begin
        n_ovld = r_ovld;
        n_out  = r_out;
        if (r_ovld && i_out_ready) begin
            n_ovld = 1'b0;
        end
        if ((r_state == S_DONE) && (!r_ovld || i_out_ready)) begin
            n_ovld = 1'b1;
            n_out  = r_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_pool  <= POOL_RST;
            r_ovld  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pool  <= n_pool;
            r_ovld  <= n_ovld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_h        <= n_h;
        r_n        <= n_n;
        r_m        <= n_m;
        r_bs       <= n_bs;
        r_best     <= n_best;
        r_is_query <= n_is_query;
        r_res      <= n_res;
        r_out      <= n_out;
    end

    // A finished transaction always appears on the output the next cycle.
    a_done_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) && (!r_ovld || i_out_ready) |=> o_out_valid)
        else $error("finished result was not presented");

    // A zero-size allocate goes straight to the result with its own status.
    a_zero_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && (i_in.func == FUNC_ALLOC) && (i_in.req_size == '0)
        |=> (r_state == S_DONE) && (r_res.status == ST_ZERO))
        else $error("zero-size allocate not rejected");

    // Failed transactions report neither a block nor a largest free size.
    a_fail_no_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out.status != ST_OK) |-> (o_out.block_address == '0) &&
        (o_out.largest_free == '0))
        else $error("failed transaction reports an address");

    // Returned payload offsets are word aligned.
    a_addr_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out.status == ST_OK) && (o_out.block_address != '0)
        |-> (o_out.block_address[WB_SH-1:0] == '0))
        else $error("allocated offset is not word aligned");

    // The pool size always stays word aligned and within the memory.
    a_pool_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pool[WB_SH-1:0] == '0) && (r_pool >= K_2WB) && (r_pool <= POOL_LIM))
        else $error("pool size out of range");

endmodule
